// File: rtl/adsr_envelope_generator_macros.svh
// -----------------------------------------------------------------------------
// ADSR envelope generator assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// -----------------------------------------------------------------------------
`ifndef ADSR_ENVELOPE_GENERATOR_MACROS_SVH
`define ADSR_ENVELOPE_GENERATOR_MACROS_SVH

// same-cycle implication
`define ADSR_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ADSR_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/adsr_pkg.sv
// -----------------------------------------------------------------------------
// ADSR package
// Shared types, register indexes, reset values and step constants.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package adsr_pkg;

	// register map
	typedef enum logic [2:0] {
		REG_ATTACK_TIME   = 3'd0,
		REG_DECAY_TIME    = 3'd1,
		REG_SUSTAIN_KNOB  = 3'd2,
		REG_RELEASE_TIME  = 3'd3,
		REG_MIN_LEVEL     = 3'd4,
		REG_SUSTAIN_FLOOR = 3'd5,
		REG_FULL_SCALE    = 3'd6
	} reg_idx_t;

	localparam logic [7:0] RST_ATTACK_TIME   = 8'd64;
	localparam logic [7:0] RST_DECAY_TIME    = 8'd64;
	localparam logic [7:0] RST_SUSTAIN_KNOB  = 8'd127;
	localparam logic [7:0] RST_RELEASE_TIME  = 8'd64;
	localparam logic [7:0] RST_MIN_LEVEL     = 8'd40;
	localparam logic [7:0] RST_SUSTAIN_FLOOR = 8'd40;
	localparam logic [7:0] RST_FULL_SCALE    = 8'd255;

	localparam logic [7:0] RST_PEAK_LEVEL    = 8'd127;
	localparam logic [7:0] RST_SUSTAIN_LEVEL = 8'd127;

	// step thresholds and sizes
	localparam logic [7:0] ATT_SLOW_MIN  = 8'd192;
	localparam logic [7:0] ATT_TOP       = 8'd253;
	localparam logic [7:0] DEC_FAST_MAX  = 8'd48;
	localparam logic [7:0] DEC_MID_MAX   = 8'd96;
	localparam logic [7:0] DEC_FAST_STEP = 8'd4;
	localparam logic [7:0] DEC_MID_STEP  = 8'd2;
	localparam logic [7:0] DEC_SLOW_STEP = 8'd1;
	localparam logic [8:0] ATT_FAST_INC  = 9'd2;
	localparam logic [8:0] ATT_SLOW_INC  = 9'd1;

	typedef enum logic [1:0] {
		PH_ATTACK  = 2'd0,
		PH_DECAY   = 2'd1,
		PH_SUSTAIN = 2'd2,
		PH_RELEASE = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STEP,
		ST_SUS_A,
		ST_SUS_B,
		ST_SUS_W,
		ST_DUTY,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		MUL_PEAK,
		MUL_SUS_A,
		MUL_SUS_B,
		MUL_DUTY
	} mul_sel_t;

	typedef struct packed {
		logic [7:0] attack_time;
		logic [7:0] decay_time;
		logic [7:0] sustain_knob;
		logic [7:0] release_time;
		logic [7:0] min_level;
		logic [7:0] sustain_floor;
		logic [7:0] full_scale;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic     capture;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     step;
		logic     sus_wr;
		logic     out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic sus_entry;
	} sts_t;

endpackage

// File: rtl/adsr_envelope_generator.sv
// -----------------------------------------------------------------------------
// ADSR envelope generator
// Tick-driven attack/decay/sustain/release envelope with VCA duty output.
//
// Usage:
//   Input channel (in_valid / in_stall): one request per envelope tick with
//   key_held, note_start, velocity and lfo_amplitude. A request is taken when
//   in_valid is high and in_stall is low; in_stall is low only while the
//   sequencer is idle.
//   Output channel (out_valid / out_stall): exactly one result per request:
//   envelope, phase, note_on and vca_duty.
//   Sequence: a tick runs through accept, step, duty multiply and output
//   load; on the tick that enters decay, the sustain level needs two more
//   passes through the single shared 8x8 multiplier plus a write-back,
//   between the step and the duty multiply.
//   Stall: the result register holds while out_stall is high; a new request
//   is still taken and worked up to its output load, which then waits.
//   Reset: arst_n clears the sequencer, the envelope state and the registers
//   to their default knob values; the first request may follow at once.
//   Configuration: APB writes at byte address 4*index, always ready. Write
//   registers only while no request is in flight.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adsr_envelope_generator (
	input  logic        clk,
	input  logic        arst_n,
	// tick requests
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        key_held,
	input  logic        note_start,
	input  logic [6:0]  velocity,
	input  logic [7:0]  lfo_amplitude,
	// results
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  envelope,
	output logic [1:0]  phase,
	output logic        note_on,
	output logic [7:0]  vca_duty,
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import adsr_pkg::*;

	cfg_t       cfg_q;
	cmd_t       cmd;
	sts_t       sts;
	logic       reg_wr;
	reg_idx_t   reg_idx;
	logic [7:0] rd_val;

	// register file: write on the access phase, low byte only
	assign pready  = 1'b1;
	assign reg_wr  = psel && penable && pwrite;
	assign reg_idx = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.attack_time   <= RST_ATTACK_TIME;
			cfg_q.decay_time    <= RST_DECAY_TIME;
			cfg_q.sustain_knob  <= RST_SUSTAIN_KNOB;
			cfg_q.release_time  <= RST_RELEASE_TIME;
			cfg_q.min_level     <= RST_MIN_LEVEL;
			cfg_q.sustain_floor <= RST_SUSTAIN_FLOOR;
			cfg_q.full_scale    <= RST_FULL_SCALE;
		end else if (reg_wr) begin
			// an address past the last register is dropped
			unique case (reg_idx)
				REG_ATTACK_TIME:   cfg_q.attack_time   <= pwdata[7:0];
				REG_DECAY_TIME:    cfg_q.decay_time    <= pwdata[7:0];
				REG_SUSTAIN_KNOB:  cfg_q.sustain_knob  <= pwdata[7:0];
				REG_RELEASE_TIME:  cfg_q.release_time  <= pwdata[7:0];
				REG_MIN_LEVEL:     cfg_q.min_level     <= pwdata[7:0];
				REG_SUSTAIN_FLOOR: cfg_q.sustain_floor <= pwdata[7:0];
				REG_FULL_SCALE:    cfg_q.full_scale    <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_ATTACK_TIME:   rd_val = cfg_q.attack_time;
			REG_DECAY_TIME:    rd_val = cfg_q.decay_time;
			REG_SUSTAIN_KNOB:  rd_val = cfg_q.sustain_knob;
			REG_RELEASE_TIME:  rd_val = cfg_q.release_time;
			REG_MIN_LEVEL:     rd_val = cfg_q.min_level;
			REG_SUSTAIN_FLOOR: rd_val = cfg_q.sustain_floor;
			REG_FULL_SCALE:    rd_val = cfg_q.full_scale;
			default:           rd_val = 8'd0;
		endcase
	end

	assign prdata = {24'd0, rd_val};

	// sequencer: advances one tick request through the datapath
	adsr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// envelope state, shared multiplier and result register
	adsr_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.cmd           (cmd),
		.sts           (sts),
		.key_held      (key_held),
		.note_start    (note_start),
		.velocity      (velocity),
		.lfo_amplitude (lfo_amplitude),
		.envelope      (envelope),
		.phase         (phase),
		.note_on       (note_on),
		.vca_duty      (vca_duty)
	);

endmodule

// File: rtl/adsr_ctrl.sv
// -----------------------------------------------------------------------------
// ADSR controller
// Sequences one tick through step, sustain scaling, duty and output load.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "adsr_envelope_generator_macros.svh"

module adsr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  adsr_pkg::sts_t sts,
	output adsr_pkg::cmd_t cmd
);
	import adsr_pkg::*;

	state_t state_q, state_nxt;
	logic   out_valid_q, out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		state_nxt   = state_q;
		in_stall    = 1'b1;
		cmd         = '0;
		cmd.mul_sel = MUL_PEAK;
		unique case (state_q)
			ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.capture = in_valid;
				cmd.mul_en  = in_valid;
				if (in_valid) begin
					state_nxt = ST_STEP;
				end
			end
			ST_STEP: begin
				cmd.step  = 1'b1;
				state_nxt = sts.sus_entry ? ST_SUS_A : ST_DUTY;
			end
			ST_SUS_A: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_SUS_A;
				state_nxt   = ST_SUS_B;
			end
			ST_SUS_B: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_SUS_B;
				state_nxt   = ST_SUS_W;
			end
			ST_SUS_W: begin
				cmd.sus_wr = 1'b1;
				state_nxt  = ST_DUTY;
			end
			ST_DUTY: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_DUTY;
				state_nxt   = ST_OUT;
			end
			ST_OUT: begin
				// hold until the output register is free
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	`ADSR_ASSERT_NXT(a_accept_to_step, in_valid && !in_stall, state_q == ST_STEP, "accepted request did not start a step")
	`ADSR_ASSERT_NXT(a_result_held, out_valid_q && out_stall, out_valid_q, "stalled result dropped")
	`ADSR_ASSERT_NXT(a_out_wait, state_q == ST_OUT && !out_free, state_q == ST_OUT && out_valid_q, "left output wait while stalled")

endmodule

// File: rtl/adsr_dp.sv
// -----------------------------------------------------------------------------
// ADSR datapath
// Envelope state, one shared 8x8 multiplier and the result register.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "adsr_envelope_generator_macros.svh"

module adsr_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  adsr_pkg::cfg_t  cfg,
	input  adsr_pkg::cmd_t  cmd,
	output adsr_pkg::sts_t  sts,
	input  logic           key_held,
	input  logic           note_start,
	input  logic [6:0]     velocity,
	input  logic [7:0]     lfo_amplitude,
	output logic [7:0]     envelope,
	output logic [1:0]     phase,
	output logic           note_on,
	output logic [7:0]     vca_duty
);
	import adsr_pkg::*;

	// tick request fields
	logic       key_q, start_q;
	logic [7:0] amp_q;
	logic [15:0] prod_q;

	// envelope state
	logic [7:0] countdown_q, peak_q, sus_q, env_q;
	phase_t     phase_q;
	logic       note_on_q;

	// result register
	logic [7:0] envelope_q, duty_q;
	phase_t     phase_out_q;
	logic       note_on_out_q;

	logic [7:0] mul_a, mul_b;
	logic [7:0] span_min, span_sf;
	logic [7:0] peak_sum, sus_sum;
	logic [8:0] att_sum;
	logic [7:0] peak_eff, dec_base, dec_amt, prod_hi;
	logic       att_slow;
	phase_t     ph_pre, ph_nxt;
	logic [7:0] cd_nxt, env_nxt;
	logic       on_nxt, sus_entry;
	logic       cd_wait;

	assign span_min = (cfg.full_scale > cfg.min_level) ?
		(cfg.full_scale - cfg.min_level) : 8'd0;
	assign span_sf  = (cfg.full_scale > cfg.sustain_floor) ?
		(cfg.full_scale - cfg.sustain_floor) : 8'd0;
	assign prod_hi  = prod_q[15:8];

	always_comb begin
		unique case (cmd.mul_sel)
			MUL_PEAK: begin
				mul_a = {velocity, 1'b0};
				mul_b = span_min;
			end
			MUL_SUS_A: begin
				mul_a = peak_q;
				mul_b = cfg.sustain_knob;
			end
			MUL_SUS_B: begin
				mul_a = prod_hi;
				mul_b = span_sf;
			end
			MUL_DUTY: begin
				mul_a = env_q;
				mul_b = amp_q;
			end
			default: begin
				mul_a = env_q;
				mul_b = amp_q;
			end
		endcase
	end

	assign peak_sum = prod_hi + cfg.min_level;
	assign sus_sum  = prod_hi + cfg.sustain_floor;
	assign peak_eff = start_q ? peak_sum : peak_q;
	assign att_slow = (cfg.attack_time >= ATT_SLOW_MIN);
	assign att_sum  = {1'b0, env_q} + (att_slow ? ATT_SLOW_INC : ATT_FAST_INC);
	assign dec_base = env_q - 8'd1;

	always_comb begin
		if (cfg.decay_time < DEC_FAST_MAX) begin
			dec_amt = DEC_FAST_STEP;
		end else if (cfg.decay_time < DEC_MID_MAX) begin
			dec_amt = DEC_MID_STEP;
		end else begin
			dec_amt = DEC_SLOW_STEP;
		end
	end

	always_comb begin
		ph_pre = phase_q;
		if (start_q) begin
			ph_pre = PH_ATTACK;
		end
		if (!key_q) begin
			ph_pre = PH_RELEASE;
		end
		ph_nxt    = ph_pre;
		cd_nxt    = countdown_q - 8'd1;
		env_nxt   = env_q;
		on_nxt    = key_q ? 1'b1 : note_on_q;
		sus_entry = 1'b0;
		if (countdown_q == 8'd0) begin
			unique case (ph_pre)
				PH_ATTACK: begin
					if (env_q < peak_eff) begin
						cd_nxt = att_slow ? (cfg.attack_time >> 1) : (cfg.attack_time >> 2);
						if (env_q >= ATT_TOP || att_sum > {1'b0, cfg.full_scale}) begin
							env_nxt = cfg.full_scale;
						end else begin
							env_nxt = att_sum[7:0];
						end
					end else begin
						ph_nxt    = PH_DECAY;
						cd_nxt    = cfg.decay_time >> 2;
						sus_entry = 1'b1;
					end
				end
				PH_DECAY: begin
					if (env_q > sus_q) begin
						cd_nxt  = cfg.decay_time;
						env_nxt = (dec_base > dec_amt) ? (dec_base - dec_amt) : 8'd0;
					end else begin
						ph_nxt = PH_SUSTAIN;
						cd_nxt = countdown_q;
					end
				end
				PH_SUSTAIN: begin
					cd_nxt = countdown_q;
				end
				PH_RELEASE: begin
					if (key_q) begin
						ph_nxt = PH_ATTACK;
						cd_nxt = cfg.attack_time;
					end else if (env_q > cfg.min_level) begin
						env_nxt = dec_base;
						cd_nxt  = cfg.release_time >> 2;
					end else begin
						ph_nxt = PH_ATTACK;
						cd_nxt = cfg.attack_time;
						on_nxt = 1'b0;
					end
				end
				default: begin
					cd_nxt = countdown_q;
				end
			endcase
		end
	end

	assign sts.sus_entry = sus_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			countdown_q <= 8'd0;
			phase_q     <= PH_ATTACK;
			peak_q      <= RST_PEAK_LEVEL;
			sus_q       <= RST_SUSTAIN_LEVEL;
			env_q       <= 8'd0;
			note_on_q   <= 1'b0;
		end else begin
			if (cmd.step) begin
				countdown_q <= cd_nxt;
				phase_q     <= ph_nxt;
				peak_q      <= peak_eff;
				env_q       <= env_nxt;
				note_on_q   <= on_nxt;
			end
			if (cmd.sus_wr) begin
				sus_q <= sus_sum;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			key_q   <= key_held;
			start_q <= note_start;
			amp_q   <= lfo_amplitude;
		end
		if (cmd.mul_en) begin
			prod_q <= {8'd0, mul_a} * {8'd0, mul_b};
		end
		if (cmd.out_load) begin
			envelope_q    <= env_q;
			phase_out_q   <= phase_q;
			note_on_out_q <= note_on_q;
			duty_q        <= (prod_hi < cfg.min_level) ? cfg.min_level : prod_hi;
		end
	end

	assign envelope = envelope_q;
	assign phase    = phase_out_q;
	assign note_on  = note_on_out_q;
	assign vca_duty = duty_q;

	// a step that counts the wait down and leaves the envelope level as it is
	assign cd_wait = cmd.step && (countdown_q != 8'd0);

	`ADSR_ASSERT_NXT(a_cd_count, cd_wait, countdown_q == $past(countdown_q) - 8'd1, "wait not counted")
	`ADSR_ASSERT_NXT(a_cd_hold, cd_wait, env_q == $past(env_q), "countdown tick changed envelope")
	`ADSR_ASSERT_IMP(a_note_end, $fell(note_on_q), phase_q == PH_ATTACK, "note ended outside release")

endmodule
